// ===== design/pcc_pkg.sv =====
`timescale 1ns / 1ps
package pcc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_SECONDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUX_PERIOD = 2'd3;

  localparam logic [15:0] YELLOW_TICKS_RST = 16'd3000;
  localparam logic [6:0]  WALK_SECONDS_RST = 7'd10;
  localparam logic [15:0] TICKS_PER_SEC_RST = 16'd1000;
  localparam logic [7:0]  MUX_PERIOD_RST = 8'd5;
  localparam logic [6:0]  WALK_SECONDS_MAX = 7'd99;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_YELLOW = 2'd1,
    PH_WALK   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] yellow_ticks;
    logic [6:0]  walk_seconds;
    logic [15:0] ticks_per_second;
    logic [7:0]  mux_period_ticks;
  } pcc_cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] seconds_left;
    logic       show_units;
  } pcc_view_t;

  typedef struct packed {
    logic       car_green;
    logic       car_yellow;
    logic       car_red;
    logic       walk_green;
    logic       walk_red;
    logic [7:0] segments;
    logic       tens_enable;
    logic       units_enable;
  } pcc_word_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0: p = 8'hBF;
      4'd1: p = 8'h86;
      4'd2: p = 8'hDB;
      4'd3: p = 8'hCF;
      4'd4: p = 8'hE6;
      4'd5: p = 8'hED;
      4'd6: p = 8'hFD;
      4'd7: p = 8'h87;
      4'd8: p = 8'hFF;
      4'd9: p = 8'hEF;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // exact for 0..99: v / 10 == (v * 205) >> 11
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

endpackage

// ===== design/pcc_if.sv =====
`timescale 1ns / 1ps
interface pcc_in_if;
  logic valid;
  logic ready;
  logic button_pressed;

  modport source(output valid, output button_pressed, input ready);
  modport sink(input valid, input button_pressed, output ready);
endinterface

interface pcc_out_if;
  logic       valid;
  logic       ready;
  logic       car_green;
  logic       car_yellow;
  logic       car_red;
  logic       walk_green;
  logic       walk_red;
  logic [7:0] segments;
  logic       tens_enable;
  logic       units_enable;

  modport source(output valid, output car_green, output car_yellow, output car_red,
                 output walk_green, output walk_red, output segments,
                 output tens_enable, output units_enable, input ready);
  modport sink(input valid, input car_green, input car_yellow, input car_red,
               input walk_green, input walk_red, input segments,
               input tens_enable, input units_enable, output ready);
endinterface

// ===== design/pcc_cfg_regs.sv =====
`timescale 1ns / 1ps
module pcc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data,
  output pcc_pkg::pcc_cfg_t             cfg
);

  logic [15:0] yellow_r;
  logic [6:0]  walk_r;
  logic [15:0] tps_r;
  logic [7:0]  mux_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yellow_r <= pcc_pkg::YELLOW_TICKS_RST;
      walk_r   <= pcc_pkg::WALK_SECONDS_RST;
      tps_r    <= pcc_pkg::TICKS_PER_SEC_RST;
      mux_r    <= pcc_pkg::MUX_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcc_pkg::CFG_YELLOW_TICKS: begin
          yellow_r <= cfg_data;
        end
        pcc_pkg::CFG_WALK_SECONDS: begin
          walk_r <= cfg_data[6:0];
        end
        pcc_pkg::CFG_TICKS_PER_SEC: begin
          tps_r <= cfg_data;
        end
        pcc_pkg::CFG_MUX_PERIOD: begin
          mux_r <= cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // zero acts as one; walk start clamped to 1..99
  always_comb begin
    cfg.yellow_ticks     = (yellow_r == 16'd0) ? 16'd1 : yellow_r;
    cfg.ticks_per_second = (tps_r == 16'd0) ? 16'd1 : tps_r;
    cfg.mux_period_ticks = (mux_r == 8'd0) ? 8'd1 : mux_r;
    if (walk_r == 7'd0) begin
      cfg.walk_seconds = 7'd1;
    end else if (walk_r > pcc_pkg::WALK_SECONDS_MAX) begin
      cfg.walk_seconds = pcc_pkg::WALK_SECONDS_MAX;
    end else begin
      cfg.walk_seconds = walk_r;
    end
  end

endmodule

// ===== design/pcc_seq_core.sv =====
`timescale 1ns / 1ps
module pcc_seq_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               button_pressed,
  input  pcc_pkg::pcc_cfg_t  cfg,
  output pcc_pkg::pcc_view_t view
);

  pcc_pkg::phase_t phase_r, phase_nxt;
  logic        request_r, request_nxt;
  logic [15:0] phase_ticks_r, phase_ticks_nxt;
  logic [6:0]  seconds_r, seconds_nxt;
  logic [7:0]  mux_ticks_r, mux_ticks_nxt;
  logic        show_units_r, show_units_nxt;

  logic [15:0] pt_inc;
  logic [7:0]  mt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= pcc_pkg::PH_IDLE;
      request_r     <= 1'b0;
      phase_ticks_r <= 16'd0;
      seconds_r     <= 7'd0;
      mux_ticks_r   <= 8'd0;
      show_units_r  <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      request_r     <= request_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      seconds_r     <= seconds_nxt;
      mux_ticks_r   <= mux_ticks_nxt;
      show_units_r  <= show_units_nxt;
    end
  end

  assign pt_inc = phase_ticks_r + 16'd1;
  assign mt_inc = mux_ticks_r + 8'd1;

  always_comb begin
    phase_nxt       = phase_r;
    request_nxt     = request_r;
    phase_ticks_nxt = phase_ticks_r;
    seconds_nxt     = seconds_r;
    mux_ticks_nxt   = mux_ticks_r;
    show_units_nxt  = show_units_r;
    unique case (phase_r)
      pcc_pkg::PH_YELLOW: begin
        phase_ticks_nxt = pt_inc;
        if (pt_inc == 16'd0 || pt_inc >= cfg.yellow_ticks) begin
          phase_nxt       = pcc_pkg::PH_WALK;
          phase_ticks_nxt = 16'd0;
          seconds_nxt     = cfg.walk_seconds;
          mux_ticks_nxt   = 8'd0;
          show_units_nxt  = 1'b0;
        end
      end
      pcc_pkg::PH_WALK: begin
        mux_ticks_nxt = mt_inc;
        if (mt_inc == 8'd0 || mt_inc >= cfg.mux_period_ticks) begin
          mux_ticks_nxt  = 8'd0;
          show_units_nxt = ~show_units_r;
        end
        phase_ticks_nxt = pt_inc;
        if (pt_inc == 16'd0 || pt_inc >= cfg.ticks_per_second) begin
          phase_ticks_nxt = 16'd0;
          seconds_nxt     = (seconds_r == 7'd0) ? 7'd0 : seconds_r - 7'd1;
          if (seconds_r <= 7'd1) begin
            phase_nxt      = pcc_pkg::PH_IDLE;
            mux_ticks_nxt  = 8'd0;
            show_units_nxt = 1'b0;
            request_nxt    = 1'b0;
          end
        end
      end
      default: begin
        if (phase_r != pcc_pkg::PH_IDLE) begin
          phase_nxt       = pcc_pkg::PH_IDLE;
          phase_ticks_nxt = 16'd0;
          mux_ticks_nxt   = 8'd0;
          show_units_nxt  = 1'b0;
        end
        if (request_r) begin
          request_nxt     = 1'b0;
          phase_nxt       = pcc_pkg::PH_YELLOW;
          phase_ticks_nxt = 16'd0;
        end else if (button_pressed) begin
          request_nxt = 1'b1;
        end
      end
    endcase
  end

  assign view.phase        = phase_r;
  assign view.seconds_left = seconds_r;
  assign view.show_units   = show_units_r;

endmodule

// ===== design/pcc_display.sv =====
`timescale 1ns / 1ps
module pcc_display (
  input  pcc_pkg::pcc_view_t view,
  output pcc_pkg::pcc_word_t word
);

  logic [3:0] tens;
  logic [6:0] tens_x10;
  logic [3:0] units;

  assign tens     = pcc_pkg::tens_of(view.seconds_left);
  assign tens_x10 = 7'({tens, 3'b000} + {2'b00, tens, 1'b0});
  assign units    = 4'(view.seconds_left - tens_x10);

  always_comb begin
    word = '0;
    unique case (view.phase)
      pcc_pkg::PH_YELLOW: begin
        word.car_yellow = 1'b1;
        word.walk_red   = 1'b1;
      end
      pcc_pkg::PH_WALK: begin
        word.car_red    = 1'b1;
        word.walk_green = 1'b1;
        if (view.show_units) begin
          word.segments     = pcc_pkg::seg_pattern(units);
          word.units_enable = 1'b1;
        end else begin
          word.segments    = pcc_pkg::seg_pattern(tens);
          word.tens_enable = 1'b1;
        end
      end
      default: begin
        word.car_green = 1'b1;
        word.walk_red  = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/pedestrian_crossing_controller.sv =====
`timescale 1ns / 1ps
// Pedestrian crossing controller. Each input word is one millisecond tick with the sampled
// button; each accepted tick yields exactly one output word with the lamp and display state
// of that tick, taken from the state before the tick updates it. One word is accepted every
// clock cycle unless out_ch stalls a full output register: the whole update is one short
// combinational pass from the state registers into a single output register, and
// in_ch.ready stays high while that register is empty or being drained. Timing registers
// on the cfg_ port are to be written only while the block is idle; the block does not
// enforce this. A zero timing value acts as one and the walk start is limited to 1..99.
module pedestrian_crossing_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  pcc_in_if.sink                        in_ch,
  pcc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data
);

  pcc_pkg::pcc_cfg_t  cfg;
  pcc_pkg::pcc_view_t view;
  pcc_pkg::pcc_word_t word;
  pcc_pkg::pcc_word_t out_r;
  logic               out_valid_r;
  logic               accept;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  pcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcc_seq_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (accept),
    .button_pressed (in_ch.button_pressed),
    .cfg            (cfg),
    .view           (view)
  );

  pcc_display u_disp (
    .view (view),
    .word (word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= word;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.car_green    = out_r.car_green;
  assign out_ch.car_yellow   = out_r.car_yellow;
  assign out_ch.car_red      = out_r.car_red;
  assign out_ch.walk_green   = out_r.walk_green;
  assign out_ch.walk_red     = out_r.walk_red;
  assign out_ch.segments     = out_r.segments;
  assign out_ch.tens_enable  = out_r.tens_enable;
  assign out_ch.units_enable = out_r.units_enable;

endmodule

// ===== design/pcc_checker.sv =====
`timescale 1ns / 1ps
module pcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       car_green,
  input logic       car_yellow,
  input logic       car_red,
  input logic       walk_green,
  input logic       walk_red,
  input logic [7:0] segments,
  input logic       tens_enable,
  input logic       units_enable
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(segments) && $stable(car_red))
    else $error("output word changed while stalled");

  a_car_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({car_green, car_yellow, car_red}))
    else $error("car lamps not one-hot");

  a_walk_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (walk_green == car_red) && (walk_red == !walk_green))
    else $error("pedestrian lamps disagree with car lamps");

  a_digit_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (car_red ? (tens_enable ^ units_enable)
                           : (!tens_enable && !units_enable && segments == 8'h00)))
    else $error("digit drivers wrong for phase");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind pedestrian_crossing_controller pcc_checker u_pcc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .car_green    (out_ch.car_green),
  .car_yellow   (out_ch.car_yellow),
  .car_red      (out_ch.car_red),
  .walk_green   (out_ch.walk_green),
  .walk_red     (out_ch.walk_red),
  .segments     (out_ch.segments),
  .tens_enable  (out_ch.tens_enable),
  .units_enable (out_ch.units_enable)
);
